@@ src/cec_pkg.sv @@
// shared types, constants and calendar table for the calendar epoch converter
`timescale 1ns / 1ps
`default_nettype none
package cec_pkg;

  typedef enum logic [1:0] {
    OP_TO_EPOCH  = 2'd0,
    OP_TO_DATE   = 2'd1,
    OP_ADD_HOURS = 2'd2,
    OP_ADD_DAYS  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] mday;
    logic [3:0] month;
    logic [6:0] year;
  } echo_t;

  typedef struct packed {
    echo_t       echo;
    logic [31:0] epoch;
  } pass_t;

  localparam int unsigned LATENCY = 10;
  localparam int unsigned DEC_STAGES = 6;

  localparam logic [15:0] DAYS_PER_QUAD = 16'd1461;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;

  // 86400 = 675 * 128
  localparam logic [24:0] DAY_DIV       = 25'd675;
  localparam logic [49:0] RECIP_DAY     = 50'd25451442;
  localparam logic [32:0] RECIP_HOUR    = 33'd37283;
  localparam logic [31:0] RECIP_QUAD    = 32'd45934;
  localparam logic [26:0] RECIP_MIN     = 27'd17477;

  localparam logic [10:0] CUM_DAYS [0:3][0:11] = '{
    '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
      11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
    '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
      11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
    '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
      11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
    '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
      11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
  };

endpackage
`default_nettype wire

@@ src/cec_decode.sv @@
// pipelined seconds-to-date decoder with op 0 echo selection at the output
`timescale 1ns / 1ps
`default_nettype none
module cec_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire cec_pkg::pass_t  in_data,
  output logic                 done,
  output logic [31:0]          epoch_out,
  output logic [5:0]           sec_out,
  output logic [5:0]           min_out,
  output logic [4:0]           hour_out,
  output logic [4:0]           mday_out,
  output logic [3:0]           month_out,
  output logic [7:0]           year_out
);

  cec_pkg::pass_t pipe [cec_pkg::DEC_STAGES];
  logic [cec_pkg::DEC_STAGES-1:0] vld;

  logic [15:0] q0;
  logic [15:0] q5;
  logic [10:0] r0;
  logic [15:0] days6;
  logic [16:0] rems6;
  logic [15:0] days7;
  logic [16:0] rems7;
  logic [4:0]  hour7;
  logic [5:0]  qd7;
  logic [11:0] rem2_8;
  logic [10:0] r8;
  logic [4:0]  hour8;
  logic [5:0]  qd8;
  logic [11:0] rem2_9;
  logic [10:0] r9;
  logic [4:0]  hour9;
  logic [5:0]  qd9;
  logic [5:0]  min9;
  logic [1:0]  y9;

  logic [49:0] prod4;
  logic [24:0] diff5;
  logic        ge6;
  logic [10:0] r0_sub;
  logic [32:0] prodh;
  logic [31:0] prodq;
  logic [16:0] diff8h;
  logic [15:0] diff8d;
  logic [26:0] prodm;
  logic [1:0]  y_sel;
  logic [11:0] sec_full;
  logic [3:0]  m_sel;
  logic [10:0] mday_full;

  always_comb begin
    prod4  = 50'(in_data.epoch[31:7]) * cec_pkg::RECIP_DAY;
    diff5  = pipe[0].epoch[31:7] - 25'(q0) * cec_pkg::DAY_DIV;
    ge6    = r0 >= 11'(cec_pkg::DAY_DIV);
    r0_sub = r0 - 11'(cec_pkg::DAY_DIV);
    prodh  = 33'(rems6) * cec_pkg::RECIP_HOUR;
    prodq  = 32'(days6) * cec_pkg::RECIP_QUAD;
    diff8h = rems7 - 17'(hour7) * cec_pkg::SECS_PER_HOUR;
    diff8d = days7 - 16'(qd7) * cec_pkg::DAYS_PER_QUAD;
    prodm  = 27'(rem2_8) * cec_pkg::RECIP_MIN;
    // year within the four-year group
    priority if (r8 >= cec_pkg::CUM_DAYS[3][0]) y_sel = 2'd3;
    else if (r8 >= cec_pkg::CUM_DAYS[2][0]) y_sel = 2'd2;
    else if (r8 >= cec_pkg::CUM_DAYS[1][0]) y_sel = 2'd1;
    else y_sel = 2'd0;
    sec_full = rem2_9 - 12'(min9) * 12'(cec_pkg::SECS_PER_MIN);
    m_sel = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (r9 >= cec_pkg::CUM_DAYS[y9][i]) m_sel = 4'(i);
    end
    mday_full = r9 - cec_pkg::CUM_DAYS[y9][m_sel] + 11'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[cec_pkg::DEC_STAGES-2:0], in_valid};
      done <= vld[cec_pkg::DEC_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    pipe[0] <= in_data;
    for (int i = 1; i < cec_pkg::DEC_STAGES; i++) begin
      pipe[i] <= pipe[i-1];
    end
    q0     <= prod4[49:34];
    q5     <= q0;
    r0     <= diff5[10:0];
    days6  <= q5 + 16'(ge6);
    rems6  <= {(ge6 ? r0_sub[9:0] : r0[9:0]), pipe[1].epoch[6:0]};
    days7  <= days6;
    rems7  <= rems6;
    hour7  <= prodh[31:27];
    qd7    <= prodq[31:26];
    rem2_8 <= diff8h[11:0];
    r8     <= diff8d[10:0];
    hour8  <= hour7;
    qd8    <= qd7;
    rem2_9 <= rem2_8;
    r9     <= r8;
    hour9  <= hour8;
    qd9    <= qd8;
    min9   <= prodm[25:20];
    y9     <= y_sel;
    epoch_out <= pipe[5].epoch;
    if (pipe[5].echo.op == cec_pkg::OP_TO_EPOCH) begin
      sec_out   <= pipe[5].echo.sec;
      min_out   <= pipe[5].echo.min;
      hour_out  <= pipe[5].echo.hour;
      mday_out  <= pipe[5].echo.mday;
      month_out <= pipe[5].echo.month;
      year_out  <= {1'b0, pipe[5].echo.year};
    end else begin
      sec_out   <= sec_full[5:0];
      min_out   <= min9;
      hour_out  <= hour9;
      mday_out  <= mday_full[4:0];
      month_out <= m_sel + 4'd1;
      year_out  <= {qd9, y9};
    end
  end

`ifndef SYNTHESIS
  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    vld[cec_pkg::DEC_STAGES-1] && pipe[5].echo.op != cec_pkg::OP_TO_EPOCH
    |=> sec_out < 6'd60 && min_out < 6'd60 && hour_out < 5'd24)
    else $error("decoded time of day out of range");
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    vld[cec_pkg::DEC_STAGES-1] && pipe[5].echo.op != cec_pkg::OP_TO_EPOCH
    |=> month_out >= 4'd1 && month_out <= 4'd12 && mday_out != 5'd0)
    else $error("decoded date out of range");
  a_day_split: assert property (@(posedge clk) disable iff (rst)
    vld[1] |=> rems6 < 17'(cec_pkg::SECS_PER_DAY))
    else $error("day split remainder not reduced");
`endif

endmodule
`default_nettype wire

@@ src/calendar_epoch_converter.sv @@
// top level: date to seconds front end feeding the pipelined date decoder
//
// usage
//   an item is taken at a rising edge with start high and busy low; busy is
//   always low, so one item can be started every cycle
//   opcode 0 turns the date fields into seconds since year zero and echoes
//   them; opcode 1 decodes epoch_in; opcodes 2 and 3 shift the input date by
//   shift hours or days and decode the result
//   each result appears on the result ports for exactly one cycle with done
//   high after its item has passed ten register stages: three for date to
//   seconds and the offset add, seven for the division chain and the
//   calendar table search
//   throughput is one item per cycle, results leave in the order taken
//   reset clears all valid bits; items in flight are dropped and no done is
//   raised until new items are started
//   the receiver cannot hold results off, so nothing ever stalls
`timescale 1ns / 1ps
`default_nettype none
module calendar_epoch_converter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] epoch_in,
  input  wire logic [5:0]  sec_in,
  input  wire logic [5:0]  min_in,
  input  wire logic [4:0]  hour_in,
  input  wire logic [4:0]  mday_in,
  input  wire logic [3:0]  month_in,
  input  wire logic [6:0]  year_in,
  input  wire logic [15:0] shift,
  output logic             done,
  output logic [31:0]      epoch_out,
  output logic [5:0]       sec_out,
  output logic [5:0]       min_out,
  output logic [4:0]       hour_out,
  output logic [4:0]       mday_out,
  output logic [3:0]       month_out,
  output logic [7:0]       year_out
);

  logic           accept;
  logic [3:0]     mon_idx;
  logic [31:0]    shift_ext;
  logic [31:0]    shoff_next;
  logic [31:0]    dsec_next;
  logic [31:0]    e_next;

  logic           v1, v2, v3;
  cec_pkg::echo_t echo1, echo2, echo3;
  logic [31:0]    epoch1, epoch2;
  logic [15:0]    dd1;
  logic [16:0]    tod1;
  logic [31:0]    shoff1, shoff2;
  logic [31:0]    dsec2;
  logic [31:0]    e3;
  cec_pkg::pass_t dec_in;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    // month clamped to the table
    priority if (month_in == 4'd0) mon_idx = 4'd0;
    else if (month_in > 4'd12) mon_idx = 4'd11;
    else mon_idx = month_in - 4'd1;
    shift_ext = {{16{shift[15]}}, shift};
    unique case (cec_pkg::op_t'(opcode))
      cec_pkg::OP_ADD_HOURS: shoff_next = shift_ext * 32'(cec_pkg::SECS_PER_HOUR);
      cec_pkg::OP_ADD_DAYS:  shoff_next = shift_ext * cec_pkg::SECS_PER_DAY;
      default:               shoff_next = '0;
    endcase
    dsec_next = 32'(dd1) * cec_pkg::SECS_PER_DAY + 32'(tod1);
    if (echo2.op == cec_pkg::OP_TO_DATE) e_next = epoch2;
    else e_next = dsec2 + shoff2 - cec_pkg::SECS_PER_DAY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    echo1.op    <= cec_pkg::op_t'(opcode);
    echo1.sec   <= sec_in;
    echo1.min   <= min_in;
    echo1.hour  <= hour_in;
    echo1.mday  <= mday_in;
    echo1.month <= month_in;
    echo1.year  <= year_in;
    epoch1 <= epoch_in;
    // day count plus one, the minus one is folded into the final add
    dd1    <= 16'(year_in[6:2]) * cec_pkg::DAYS_PER_QUAD
              + 16'(cec_pkg::CUM_DAYS[year_in[1:0]][mon_idx]) + 16'(mday_in);
    tod1   <= 17'(hour_in) * cec_pkg::SECS_PER_HOUR
              + 17'(min_in) * cec_pkg::SECS_PER_MIN + 17'(sec_in);
    shoff1 <= shoff_next;
    echo2  <= echo1;
    epoch2 <= epoch1;
    shoff2 <= shoff1;
    dsec2  <= dsec_next;
    echo3  <= echo2;
    e3     <= e_next;
  end

  assign dec_in.echo  = echo3;
  assign dec_in.epoch = e3;

  cec_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_data   (dec_in),
    .done      (done),
    .epoch_out (epoch_out),
    .sec_out   (sec_out),
    .min_out   (min_out),
    .hour_out  (hour_out),
    .mday_out  (mday_out),
    .month_out (month_out),
    .year_out  (year_out)
  );

`ifndef SYNTHESIS
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, cec_pkg::LATENCY))
    else $error("result without a started item");
  a_decode_epoch: assert property (@(posedge clk) disable iff (rst)
    done && $past(opcode, cec_pkg::LATENCY) == cec_pkg::OP_TO_DATE
    |-> epoch_out == $past(epoch_in, cec_pkg::LATENCY))
    else $error("decode item lost its epoch");
  a_echo_year: assert property (@(posedge clk) disable iff (rst)
    done && $past(opcode, cec_pkg::LATENCY) == cec_pkg::OP_TO_EPOCH
    |-> year_out == {1'b0, $past(year_in, cec_pkg::LATENCY)})
    else $error("echoed year mismatch");
`endif

endmodule
`default_nettype wire
